FILE: rtl/multichannel_occupancy_detector_assert.svh
// Assertion macros for the occupancy detector.
`ifndef MULTICHANNEL_OCCUPANCY_DETECTOR_ASSERT_SVH
`define MULTICHANNEL_OCCUPANCY_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define MOCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MOCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MOCC_ASSERT(lbl, clk, rstn, prop, msg)
`define MOCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/mocc_pkg.sv
// Package: constants and types of the occupancy detector.
`timescale 1ns / 1ps
package mocc_pkg;

    localparam int MAX_CHANNELS = 24;
    localparam int MIN_CHANNELS = 8;
    localparam int IDX_W        = $clog2(MAX_CHANNELS);
    localparam int CHAN_W       = 5;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CHAN_W-1:0] RESET_CHANNEL_COUNT = CHAN_W'(18);
    localparam logic [CNT_W-1:0]  RESET_WINDOW_LIMIT  = CNT_W'(50);
    localparam logic [CNT_W-1:0]  RESET_HIGH_LIMIT    = CNT_W'(45);

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = CFG_IDX_W'(2);

    typedef struct packed {
        logic             occupied;
        logic [CNT_W-1:0] high_count;
        logic [CNT_W-1:0] tick_count;
    } t_chan_state;

endpackage

FILE: rtl/multichannel_occupancy_detector.sv
// Top level: round-robin occupancy detector with per-channel state in a memory.
`timescale 1ns / 1ps
`include "multichannel_occupancy_detector_assert.svh"

// Takes one sample per cycle unless the output stalls, and returns one result transaction
// per sample: the accepting edge reads the scanned channel's counts from the state memory;
// when stage 1 advances, it updates them, writes them back and loads the output register.
// A full output register that is not taken stalls the pipeline. Channels are scanned
// in order and wrap at channel_count; each channel keeps a valid bit that reset clears,
// so all counts and occupancy read as zero after reset with no clearing pass.
module multichannel_occupancy_detector
    import mocc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_sample_high,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_scanned_channel,
    output logic                  o_event_valid,
    output logic                  o_now_occupied,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [CHAN_W-1:0] r_channel_count;
    logic [CNT_W-1:0]  r_window_limit;
    logic [CNT_W-1:0]  r_high_limit;
    logic [CHAN_W-1:0] cfg_count;

    assign cfg_count = i_cfg_data[CHAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RESET_CHANNEL_COUNT;
            r_window_limit  <= RESET_WINDOW_LIMIT;
            r_high_limit    <= RESET_HIGH_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: begin
                    if (cfg_count >= CHAN_W'(MIN_CHANNELS) &&
                        cfg_count <= CHAN_W'(MAX_CHANNELS)) begin
                        r_channel_count <= cfg_count;
                    end
                end
                CFG_WINDOW_LIMIT: r_window_limit <= i_cfg_data[CNT_W-1:0];
                CFG_HIGH_LIMIT:   r_high_limit   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_ch;
    logic             r_s1_sample;
    logic             r_out_valid;
    logic             s1_adv;
    logic             in_accept;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // scan index
    logic [IDX_W-1:0]  r_scan_idx;
    logic [IDX_W:0]    scan_next_w;
    logic [IDX_W-1:0]  n_scan_idx;

    always_comb begin
        scan_next_w = {1'b0, r_scan_idx} + (IDX_W+1)'(1);
        if ((IDX_W+1)'(scan_next_w) >= (IDX_W+1)'(r_channel_count) ||
            scan_next_w >= (IDX_W+1)'(MAX_CHANNELS)) begin
            n_scan_idx = '0;
        end else begin
            n_scan_idx = scan_next_w[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
        end else if (in_accept) begin
            r_scan_idx <= n_scan_idx;
        end
    end

    // state memory, registered read
    t_chan_state      r_mem [MAX_CHANNELS];
    t_chan_state      r_rd_data;
    logic [MAX_CHANNELS-1:0] r_mem_vld;
    logic             mem_we;
    t_chan_state      wr_data;

    assign mem_we = r_s1_valid && s1_adv;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s1_ch] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (mem_we) begin
            r_mem_vld[r_s1_ch] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ch     <= r_scan_idx;
            r_s1_sample <= i_sample_high;
        end
    end

    // update: bump counts, close window, judge occupancy
    t_chan_state      cur;
    logic [CNT_W-1:0] tick_inc;
    logic [CNT_W-1:0] high_inc;
    logic             win_close;
    logic             judged;
    logic             n_event;

    always_comb begin
        cur       = r_mem_vld[r_s1_ch] ? r_rd_data : '0;
        tick_inc  = cur.tick_count + CNT_W'(1);
        high_inc  = cur.high_count + CNT_W'(r_s1_sample);
        win_close = tick_inc > r_window_limit;
        judged    = (high_inc != '0) && (high_inc < r_high_limit);
        n_event   = win_close && (judged != cur.occupied);
        wr_data.occupied   = win_close ? judged : cur.occupied;
        wr_data.tick_count = win_close ? '0 : tick_inc;
        wr_data.high_count = win_close ? '0 : high_inc;
    end

    // output register
    logic [CHAN_W-1:0] r_out_ch;
    logic              r_out_event;
    logic              r_out_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_out_ch    <= CHAN_W'(r_s1_ch);
            r_out_event <= n_event;
            r_out_occ   <= wr_data.occupied;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_scanned_channel = r_out_ch;
    assign o_event_valid     = r_out_event;
    assign o_now_occupied    = r_out_occ;

    // consecutive ticks never touch the same channel, so no forwarding path exists
    `MOCC_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, mem_we && in_accept,
        r_s1_ch != r_scan_idx, "read and write-back hit the same channel")
    `MOCC_ASSERT(a_scan_in_range, i_clk, i_rst_n,
        (IDX_W+1)'(r_scan_idx) < (IDX_W+1)'(MAX_CHANNELS), "scan index out of range")
    `MOCC_ASSERT_IMP(a_wb_marks_valid, i_clk, i_rst_n, $past(mem_we),
        r_mem_vld[$past(r_s1_ch)], "written channel not marked valid")
    `MOCC_ASSERT_IMP(a_wb_loads_output, i_clk, i_rst_n, mem_we,
        ##1 o_out_valid, "write-back without a result")

endmodule
